// ===== rtl/mtf_pkg.sv =====
package mtf_pkg;

  // Field widths fixed by the item formats
  localparam int KEY_W     = 22;
  localparam int LABEL_W   = 64;
  localparam int VALUE_W   = 16;
  localparam int RANK_W    = 3;
  localparam int CNT_OUT_W = 3;

  // Operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  // Input item
  typedef struct packed {
    logic               op;
    logic [KEY_W-1:0]   key;
    logic [LABEL_W-1:0] label;
    logic [VALUE_W-1:0] value;
  } in_t;

  // Result item
  typedef struct packed {
    logic [RANK_W-1:0]    rank;
    logic                 entry_valid;
    logic [KEY_W-1:0]     out_key;
    logic [LABEL_W-1:0]   out_label;
    logic [VALUE_W-1:0]   out_value;
    logic                 hit;
    logic [RANK_W-1:0]    hit_rank;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 last;
  } out_t;

  // One stored list entry
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [LABEL_W-1:0] label;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic upd;  // insert at front, shift down through the hit rank
    logic rot;  // rotate toward rank 0 during a dump
  } cell_ctrl_t;

endpackage

// ===== rtl/move_to_front_recent_list.sv =====
// Channel   Ports                  Transfer when
// input     start, busy, in_data   start high and busy low at a rising edge
// result    out_valid, out_data    out_valid high for one cycle, always taken
//
// Update: its status appears the cycle after the transfer and a
//   new item may follow at the very next edge.
// Dump: the cell row rotates once per cycle, so a list of N entries gives N
//   results on consecutive cycles with busy high through the dump; the rotation
//   brings the list back to its original order. An empty dump gives one invalid result.
// Reset (rst_n low, synchronous) empties the list; entry storage is not cleared.
// Results cannot be stalled by the receiver.
module move_to_front_recent_list #(
  parameter int DEPTH = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  mtf_pkg::in_t  in_data,
  output logic          out_valid,
  output mtf_pkg::out_t out_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  mtf_pkg::out_t     out_r, out_nxt;

  mtf_pkg::cell_ctrl_t ctrl;
  mtf_pkg::entry_t     new_entry;
  mtf_pkg::entry_t     ent      [DEPTH];
  logic [DEPTH-1:0]    occ;
  logic [DEPTH-1:0]    last_cell;
  logic [DEPTH-1:0]    match;
  logic [DEPTH-1:0]    found_in;
  logic [DEPTH-1:0]    found_out;

  logic              accept, do_upd, do_dump, hit, full, dump_last;
  logic [IDX_W-1:0]  hrank;

  assign busy      = (state_r == ST_DUMP);
  assign accept    = start && !busy;
  assign do_upd    = accept && (in_data.op == mtf_pkg::OP_UPDATE);
  assign do_dump   = accept && (in_data.op == mtf_pkg::OP_DUMP);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign dump_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  assign ctrl.upd  = do_upd;
  assign ctrl.rot  = (state_r == ST_DUMP);

  assign new_entry.key   = in_data.key;
  assign new_entry.label = in_data.label;
  assign new_entry.value = in_data.value;

  // Cell row: rank 0 takes the new entry, each rank hands to the next
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      mtf_pkg::entry_t prev_e;
      mtf_pkg::entry_t next_e;

      assign occ[gi]       = (CNT_W'(gi) < count_r);
      assign last_cell[gi] = (CNT_W'(gi + 1) == count_r);

      if (gi == 0) begin : g_head
        assign prev_e       = new_entry;
        assign found_in[gi] = 1'b0;
      end else begin : g_body
        assign prev_e       = ent[gi-1];
        assign found_in[gi] = found_out[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign next_e = ent[gi];
      end else begin : g_mid
        assign next_e = ent[gi+1];
      end

      mtf_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .lookup_key (in_data.key),
        .occupied   (occ[gi]),
        .found_in   (found_in[gi]),
        .is_last    (last_cell[gi]),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .head_entry (ent[0]),
        .entry      (ent[gi]),
        .match      (match[gi]),
        .found_out  (found_out[gi])
      );
    end
  endgenerate

  assign hit = found_out[DEPTH-1];

  // Rank of the first match; only one cell can be first
  always_comb begin
    hrank = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i] && !found_in[i]) begin
        hrank = hrank | IDX_W'(i);
      end
    end
  end

  // Control and result selection
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = '0;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;

    case (state_r)
      ST_IDLE: begin
        if (do_upd) begin
          if (!hit && !full) begin
            count_nxt = count_r + CNT_W'(1);
          end
          out_valid_nxt       = 1'b1;
          out_nxt.entry_valid = 1'b1;
          out_nxt.out_key     = in_data.key;
          out_nxt.out_label   = in_data.label;
          out_nxt.out_value   = in_data.value;
          out_nxt.hit         = hit;
          out_nxt.hit_rank    = mtf_pkg::RANK_W'(hrank);
          out_nxt.entry_count = mtf_pkg::CNT_OUT_W'(count_nxt);
          out_nxt.last        = 1'b1;
        end else if (do_dump) begin
          if (count_r == '0) begin
            // empty list: a single invalid result
            out_valid_nxt = 1'b1;
            out_nxt.last  = 1'b1;
          end else begin
            state_nxt = ST_DUMP;
          end
        end
      end
      ST_DUMP: begin
        out_valid_nxt       = 1'b1;
        out_nxt.rank        = mtf_pkg::RANK_W'(idx_r);
        out_nxt.entry_valid = 1'b1;
        out_nxt.out_key     = ent[0].key;
        out_nxt.out_label   = ent[0].label;
        out_nxt.out_value   = ent[0].value;
        out_nxt.entry_count = mtf_pkg::CNT_OUT_W'(count_r);
        out_nxt.last        = dump_last;
        if (dump_last) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/mtf_cell.sv =====
module mtf_cell (
  input  logic                            clk,
  input  mtf_pkg::cell_ctrl_t             ctrl,
  input  logic [mtf_pkg::KEY_W-1:0]       lookup_key,
  input  logic                            occupied,
  input  logic                            found_in,
  input  logic                            is_last,
  input  mtf_pkg::entry_t                 prev_entry,
  input  mtf_pkg::entry_t                 next_entry,
  input  mtf_pkg::entry_t                 head_entry,
  output mtf_pkg::entry_t                 entry,
  output logic                            match,
  output logic                            found_out
);

  mtf_pkg::entry_t entry_r;
  mtf_pkg::entry_t entry_nxt;

  // Key compare, only on held ranks
  assign match     = occupied && (entry_r.key == lookup_key);
  assign found_out = found_in || match;
  assign entry     = entry_r;

  // Update: take the neighbor above until the hit rank is passed.
  // Dump: rotate up, the head wraps around to the last held rank.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.upd && !found_in) begin
      entry_nxt = prev_entry;
    end else if (ctrl.rot) begin
      entry_nxt = is_last ? head_entry : next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
